// ===== rtl/pexh_pkg.sv =====
// types, commands and constants shared by the photon exit histogram modules
// no dependencies
package pexh_pkg;

    localparam int ITEM_W   = 216;
    localparam int RES_W    = 64;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 24;
    localparam int TERMS    = 12;
    localparam int FLUSH_N  = 12;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam logic [CFG_IW-1:0] REG_NUM_COEFFS  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_MU_0        = 3'd1;
    localparam logic [CFG_IW-1:0] REG_MU_1        = 3'd2;
    localparam logic [CFG_IW-1:0] REG_MU_2        = 3'd3;
    localparam logic [CFG_IW-1:0] REG_MU_3        = 3'd4;
    localparam logic [CFG_IW-1:0] REG_DETECTOR_Z  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_GRID_ORIGIN = 3'd6;
    localparam logic [CFG_IW-1:0] REG_BIN_SCALE   = 3'd7;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_BIN_X,
        OP_BIN_Y,
        OP_PROD,
        OP_SER_INIT,
        OP_SER_MUL,
        OP_SER_DIV,
        OP_POW,
        OP_ATT,
        OP_E1_SAVE,
        OP_MEM_RD,
        OP_MEM_WR,
        OP_READ_RD,
        OP_OUT_LOAD
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_BIN_X,
        ST_BIN_Y,
        ST_COEF,
        ST_PROD,
        ST_PCHK,
        ST_SER_INIT,
        ST_SER_MUL,
        ST_SER_DIV,
        ST_POW,
        ST_ATT,
        ST_E1_SAVE,
        ST_MEM_RD,
        ST_MEM_WR,
        ST_RD_MEM,
        ST_RD_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t      op;
        logic [1:0]  coef;
        logic [3:0]  term_k;
        logic        x_one;
    } dp_cmd_t;

    typedef struct packed {
        logic        clr_last;
        logic        is_read;
        logic        hit;
        logic        flush;
        logic        n_zero;
        logic [2:0]  coef_cnt;
        logic        out_busy;
    } dp_stat_t;

    // reciprocal for exact floor(v/k), v below 2^31
    function automatic logic [31:0] div_mul(input logic [3:0] k);
        logic [31:0] m;
        case (k)
            4'd1:    m = 32'd2147483649;
            4'd2:    m = 32'd2147483649;
            4'd3:    m = 32'd2863311531;
            4'd4:    m = 32'd2147483649;
            4'd5:    m = 32'd3435973837;
            4'd6:    m = 32'd2863311531;
            4'd7:    m = 32'd2454267027;
            4'd8:    m = 32'd2147483649;
            4'd9:    m = 32'd3817748708;
            4'd10:   m = 32'd3435973837;
            4'd11:   m = 32'd3123612579;
            4'd12:   m = 32'd2863311531;
            default: m = 32'd2147483649;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] div_shift(input logic [3:0] k);
        logic [5:0] s;
        case (k)
            4'd1:    s = 6'd31;
            4'd2:    s = 6'd32;
            4'd3:    s = 6'd33;
            4'd4:    s = 6'd33;
            4'd5:    s = 6'd34;
            4'd6:    s = 6'd34;
            4'd7:    s = 6'd34;
            4'd8:    s = 6'd34;
            4'd9:    s = 6'd35;
            4'd10:   s = 6'd35;
            4'd11:   s = 6'd35;
            4'd12:   s = 6'd35;
            default: s = 6'd31;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/pexh_ctrl.sv =====
// sequencing state machine for the photon exit histogram
// depends on pexh_pkg
module pexh_ctrl
    import pexh_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic [2:0]  ci_reg, ci_next;
    logic [3:0]  kk_reg, kk_next;
    logic        init_reg, init_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ci_reg    <= '0;
            kk_reg    <= 4'd1;
            init_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            ci_reg    <= ci_next;
            kk_reg    <= kk_next;
            init_reg  <= init_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ci_next    = ci_reg;
        kk_next    = kk_reg;
        init_next  = init_reg;
        case (state_reg)
            ST_CLEAR:    if (stat.clr_last) state_next = ST_SER_INIT;
            ST_IDLE:     if (s_tvalid) state_next = ST_CHECK;
            ST_CHECK: begin
                if (stat.is_read) state_next = ST_RD_MEM;
                else if (stat.hit) state_next = ST_BIN_X;
                else state_next = ST_IDLE;
            end
            ST_BIN_X:    state_next = ST_BIN_Y;
            ST_BIN_Y: begin
                ci_next    = '0;
                state_next = ST_COEF;
            end
            ST_COEF:     state_next = (ci_reg == stat.coef_cnt) ? ST_MEM_RD : ST_PROD;
            ST_PROD:     state_next = ST_PCHK;
            ST_PCHK: begin
                if (stat.flush) begin
                    ci_next    = ci_reg + 3'd1;
                    state_next = ST_COEF;
                end else begin
                    state_next = ST_SER_INIT;
                end
            end
            ST_SER_INIT: begin
                kk_next    = 4'd1;
                state_next = ST_SER_MUL;
            end
            ST_SER_MUL:  state_next = ST_SER_DIV;
            ST_SER_DIV: begin
                if (kk_reg == 4'(TERMS)) begin
                    state_next = init_reg ? ST_E1_SAVE : ST_POW;
                end else begin
                    kk_next    = kk_reg + 4'd1;
                    state_next = ST_SER_MUL;
                end
            end
            ST_POW:      if (stat.n_zero) state_next = ST_ATT;
            ST_ATT: begin
                ci_next    = ci_reg + 3'd1;
                state_next = ST_COEF;
            end
            ST_E1_SAVE: begin
                init_next  = 1'b0;
                state_next = ST_IDLE;
            end
            ST_MEM_RD:   state_next = ST_MEM_WR;
            ST_MEM_WR:   state_next = ST_IDLE;
            ST_RD_MEM:   state_next = ST_RD_OUT;
            ST_RD_OUT:   if (!stat.out_busy) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.coef   = ci_reg[1:0];
        cmd.term_k = kk_reg;
        cmd.x_one  = init_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:    cmd.op = OP_CLEAR;
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = OP_LOAD;
            end
            ST_BIN_X:    cmd.op = OP_BIN_X;
            ST_BIN_Y:    cmd.op = OP_BIN_Y;
            ST_PROD:     cmd.op = OP_PROD;
            ST_SER_INIT: cmd.op = OP_SER_INIT;
            ST_SER_MUL:  cmd.op = OP_SER_MUL;
            ST_SER_DIV:  cmd.op = OP_SER_DIV;
            ST_POW:      cmd.op = stat.n_zero ? OP_NONE : OP_POW;
            ST_ATT:      cmd.op = OP_ATT;
            ST_E1_SAVE:  cmd.op = OP_E1_SAVE;
            ST_MEM_RD:   cmd.op = OP_MEM_RD;
            ST_MEM_WR:   cmd.op = OP_MEM_WR;
            ST_RD_MEM:   cmd.op = OP_READ_RD;
            ST_RD_OUT:   cmd.op = stat.out_busy ? OP_NONE : OP_OUT_LOAD;
            default:     cmd.op = OP_NONE;
        endcase
    end

    a_term_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SER_MUL || state_reg == ST_SER_DIV)
            |-> (kk_reg >= 4'd1 && kk_reg <= 4'(TERMS)))
        else $error("series term counter out of range");

    a_coef_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ci_reg <= 3'd4)
        else $error("coefficient counter out of range");

endmodule

// ===== rtl/pexh_dp.sv =====
// datapath: config registers, binning, exponential unit, bin memory, output register
// depends on pexh_pkg
module pexh_dp
    import pexh_pkg::*;
#(
    parameter int GRID_SIZE  = 64,
    parameter int MAX_COEFFS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    input  logic [ITEM_W-1:0]   s_tdata,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [RES_W-1:0]    m_tdata,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat
);

    localparam int NBINS = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(NBINS);
    localparam int CW    = $clog2(GRID_SIZE);
    localparam logic [16:0] GMAX = 17'(GRID_SIZE - 1);

    logic [2:0]   num_coeffs_reg;
    logic [19:0]  mu_reg [4];
    logic [23:0]  detector_z_reg, grid_origin_reg, bin_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_coeffs_reg  <= 3'd1;
            mu_reg[0]       <= '0;
            mu_reg[1]       <= '0;
            mu_reg[2]       <= '0;
            mu_reg[3]       <= '0;
            detector_z_reg  <= 24'd2752512;
            grid_origin_reg <= 24'd131072;
            bin_scale_reg   <= 24'd41943;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_NUM_COEFFS:  num_coeffs_reg  <= cfg_data[2:0];
                REG_MU_0:        mu_reg[0]       <= cfg_data[19:0];
                REG_MU_1:        mu_reg[1]       <= cfg_data[19:0];
                REG_MU_2:        mu_reg[2]       <= cfg_data[19:0];
                REG_MU_3:        mu_reg[3]       <= cfg_data[19:0];
                REG_DETECTOR_Z:  detector_z_reg  <= cfg_data;
                REG_GRID_ORIGIN: grid_origin_reg <= cfg_data;
                REG_BIN_SCALE:   bin_scale_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured item
    logic         func_reg;
    logic [23:0]  x_reg, y_reg, z_reg;
    logic [31:0]  len_reg [4];
    logic [11:0]  ri_reg;

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            func_reg   <= s_tuser;
            x_reg      <= s_tdata[23:0];
            y_reg      <= s_tdata[47:24];
            z_reg      <= s_tdata[71:48];
            len_reg[0] <= s_tdata[103:72];
            len_reg[1] <= s_tdata[135:104];
            len_reg[2] <= s_tdata[167:136];
            len_reg[3] <= s_tdata[199:168];
            ri_reg     <= s_tdata[211:200];
        end
    end

    // binning, one axis per cycle
    logic [23:0]        pos_sel;
    logic signed [24:0] diff;
    logic signed [49:0] bprod;
    logic [CW-1:0]      bidx;
    logic [CW-1:0]      col_reg, row_reg;

    always_comb begin
        pos_sel = (cmd.op == OP_BIN_X) ? x_reg : y_reg;
        diff    = $signed({pos_sel[23], pos_sel}) - $signed({grid_origin_reg[23], grid_origin_reg});
        bprod   = 50'(diff) * $signed({1'b0, bin_scale_reg});
        if (bprod[49]) bidx = '0;
        else if (bprod[48:32] > GMAX) bidx = GMAX[CW-1:0];
        else bidx = bprod[CW+31:32];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_BIN_X) col_reg <= bidx;
        if (cmd.op == OP_BIN_Y) row_reg <= bidx;
    end

    // exponential unit
    logic [51:0] p_reg;
    logic [3:0]  n_reg;
    logic [30:0] xs_reg, term_reg, tmp_reg, sum_reg, e1_reg;
    logic [18:0] add_reg;
    logic [61:0] tx, pw;
    logic [62:0] dprod, dq;
    logic [30:0] rnd_sum;

    always_comb begin
        tx      = 62'(term_reg) * 62'(xs_reg);
        dprod   = 63'(tmp_reg) * 63'(div_mul(cmd.term_k));
        dq      = dprod >> div_shift(cmd.term_k);
        pw      = 62'(sum_reg) * 62'(e1_reg) + 62'(Q30_ONE >> 1);
        rnd_sum = sum_reg + 31'(1 << 13);
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD:     add_reg <= '0;
            OP_PROD:     p_reg <= 52'(mu_reg[cmd.coef]) * 52'(len_reg[cmd.coef]);
            OP_SER_INIT: begin
                xs_reg   <= cmd.x_one ? Q30_ONE : {1'b0, p_reg[31:2]};
                n_reg    <= cmd.x_one ? 4'd0 : p_reg[35:32];
                term_reg <= Q30_ONE;
                sum_reg  <= Q30_ONE;
            end
            OP_SER_MUL:  tmp_reg <= tx[60:30];
            OP_SER_DIV: begin
                term_reg <= dq[30:0];
                sum_reg  <= cmd.term_k[0] ? sum_reg - dq[30:0] : sum_reg + dq[30:0];
            end
            OP_POW: begin
                sum_reg <= pw[60:30];
                n_reg   <= n_reg - 4'd1;
            end
            OP_ATT:      add_reg <= add_reg + 19'(rnd_sum[30:14]);
            OP_E1_SAVE:  e1_reg <= sum_reg;
            default: ;
        endcase
    end

    // bin memory
    logic [47:0]   mem [NBINS];
    logic [47:0]   rdata_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] bin_addr, ri_addr, addr;
    logic [31:0]   ri32;
    logic [48:0]   acc_sum;
    logic [47:0]   wdata;
    logic          we, re;

    always_comb begin
        ri32     = 32'(ri_reg);
        ri_addr  = ri32[AW-1:0];
        bin_addr = AW'(32'(row_reg) * 32'(GRID_SIZE) + 32'(col_reg));
        acc_sum  = {1'b0, rdata_reg} + 49'(add_reg);
        we       = (cmd.op == OP_CLEAR) || (cmd.op == OP_MEM_WR);
        re       = (cmd.op == OP_MEM_RD) || (cmd.op == OP_READ_RD);
        wdata    = '0;
        case (cmd.op)
            OP_CLEAR:   addr = clr_reg;
            OP_READ_RD: addr = ri_addr;
            default:    addr = bin_addr;
        endcase
        if (cmd.op == OP_MEM_WR) wdata = acc_sum[48] ? '1 : acc_sum[47:0];
    end

    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        if (re) rdata_reg <= mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) clr_reg <= '0;
        else if (cmd.op == OP_CLEAR) clr_reg <= clr_reg + AW'(1);
    end

    // output register
    logic              m_valid_reg;
    logic [RES_W-1:0]  m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (cmd.op == OP_OUT_LOAD) m_valid_reg <= 1'b1;
        else if (m_tready) m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT_LOAD)
            m_data_reg <= {4'd0, (ri32 < 32'(NBINS)) ? rdata_reg : 48'd0, ri_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        stat.clr_last = (clr_reg == AW'(NBINS - 1));
        stat.is_read  = func_reg;
        stat.hit      = (z_reg == detector_z_reg);
        stat.flush    = (p_reg[51:32] >= 20'(FLUSH_N));
        stat.n_zero   = (n_reg == 4'd0);
        stat.coef_cnt = (num_coeffs_reg > 3'(MAX_COEFFS)) ? 3'(MAX_COEFFS) : num_coeffs_reg;
        stat.out_busy = m_valid_reg && !m_tready;
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT_LOAD) |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.op == OP_OUT_LOAD))
        else $error("result valid without load");

    a_single_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(we && re))
        else $error("memory written and read together");

endmodule

// ===== rtl/photon_exit_attenuation_histogram_top.sv =====
// top level of the photon exit attenuation histogram
// depends on pexh_pkg, pexh_ctrl, pexh_dp
// after reset: clear pass over all GRID_SIZE*GRID_SIZE bins, then the series computes e^-1
// read item: bin memory read, then load of the result register, one item at a time
// accumulate item: dropped on a miss; on a hit each coefficient takes the product, then
// the series on the shared series multiply/divide unit unless the exponent flushes
// reset is synchronous active low and sets control state and config registers to their reset values
module photon_exit_attenuation_histogram_top
    import pexh_pkg::*;
#(
    parameter int GRID_SIZE  = 64,
    parameter int MAX_COEFFS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // pos_x, pos_y, pos_z, path_len_0..3, read_index, zero pad
    input  logic [ITEM_W-1:0]   s_tdata,
    // func
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // bin_index, bin_value, zero pad
    output logic [RES_W-1:0]    m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    pexh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pexh_dp #(
        .GRID_SIZE  (GRID_SIZE),
        .MAX_COEFFS (MAX_COEFFS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
